FILE: rtl/mips_em_pkg.sv
// Shared types and constants for the MIPS execute / data-memory stage.
// Holds the operation codes, the data memory geometry and the register map.
// No dependencies.
`timescale 1ns / 1ps

package mips_em_pkg;

	// Data memory geometry: four byte lanes, one word row per address
	localparam int DATA_BYTES = 1024;
	localparam int LANES      = 4;
	localparam int ROWS       = DATA_BYTES / LANES;
	localparam int ROW_W      = $clog2(ROWS);

	// Configuration port
	localparam int  PADDR_W      = 3;
	localparam logic REG_START_PC = 1'b0;

	// Field widths
	localparam int MODE_W  = 6;
	localparam int WORD_W  = 32;
	localparam int FIELD_W = 26;

	localparam logic [WORD_W-1:0] TOP_NIBBLE_MASK = 32'hf000_0000;
	localparam logic [WORD_W-1:0] HALF_MASK       = 32'h0000_ffff;
	localparam logic [WORD_W-1:0] BYTE_MASK       = 32'h0000_00ff;

	typedef enum logic [MODE_W-1:0] {
		OP_ADD   = 6'd0,
		OP_ADDU  = 6'd1,
		OP_SUB   = 6'd2,
		OP_AND   = 6'd3,
		OP_OR    = 6'd4,
		OP_XOR   = 6'd5,
		OP_NOR   = 6'd6,
		OP_NAND  = 6'd7,
		OP_SLT   = 6'd8,
		OP_SLL   = 6'd9,
		OP_SRL   = 6'd10,
		OP_SRA   = 6'd11,
		OP_JR    = 6'd12,
		OP_MULT  = 6'd13,
		OP_MULTU = 6'd14,
		OP_MFHI  = 6'd15,
		OP_MFLO  = 6'd16,
		OP_ADDI  = 6'd17,
		OP_ADDIU = 6'd18,
		OP_LW    = 6'd19,
		OP_LH    = 6'd20,
		OP_LHU   = 6'd21,
		OP_LB    = 6'd22,
		OP_LBU   = 6'd23,
		OP_SW    = 6'd24,
		OP_SH    = 6'd25,
		OP_SB    = 6'd26,
		OP_LUI   = 6'd27,
		OP_ANDI  = 6'd28,
		OP_ORI   = 6'd29,
		OP_NORI  = 6'd30,
		OP_SLTI  = 6'd31,
		OP_BEQ   = 6'd32,
		OP_BNE   = 6'd33,
		OP_BGTZ  = 6'd34,
		OP_J     = 6'd35,
		OP_JAL   = 6'd36
	} op_t;

endpackage

FILE: rtl/mips_em_req_if.sv
// Instruction channel: valid/ready handshake with the decoded operation payload.
// Depends on mips_em_pkg for field widths.
`timescale 1ns / 1ps

interface mips_em_req_if;
	logic                                valid;
	logic                                ready;
	logic [mips_em_pkg::MODE_W-1:0]      mode;
	logic [mips_em_pkg::WORD_W-1:0]      rs_value;
	logic [mips_em_pkg::WORD_W-1:0]      rt_value;
	logic [mips_em_pkg::FIELD_W-1:0]     imm_field;

	modport source (output valid, output mode, output rs_value, output rt_value,
		output imm_field, input ready);
	modport sink (input valid, input mode, input rs_value, input rt_value,
		input imm_field, output ready);
endinterface

FILE: rtl/mips_em_rsp_if.sv
// Result channel: valid/ready handshake with result, data address and next PC.
// Depends on mips_em_pkg for field widths.
`timescale 1ns / 1ps

interface mips_em_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mips_em_pkg::WORD_W-1:0] result;
	logic [mips_em_pkg::WORD_W-1:0] data_address;
	logic [mips_em_pkg::WORD_W-1:0] next_pc;

	modport source (output valid, output result, output data_address,
		output next_pc, input ready);
	modport sink (input valid, input result, input data_address,
		input next_pc, output ready);
endinterface

FILE: rtl/mips_execute_memory_stage.sv
// Top level of the MIPS execute / data-memory stage: ALU, HI/LO multiply,
// next-PC logic and big-endian byte-lane data memory.
// Depends on mips_em_pkg, mips_em_req_if, mips_em_rsp_if and mips_em_ram.
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake           Payload
//  -------  ---  ------------------  ----------------------------------------
//  req      in   valid / ready       mode, rs_value, rt_value, imm_field
//  rsp      out  valid / ready       result, data_address, next_pc
//  APB      in   psel/penable/pready start_pc at byte address 0
//
//  One instruction is taken per cycle while req.ready is high; each result passes
//  through the data memory read, then the output register, after its transfer.
//  PC, HI and LO update at the transfer edge, so the next instruction sees them.
//  After reset the four byte-lane RAMs are cleared, one row at a time:
//  all ROWS (256) rows, with req.ready low. APB writes are taken throughout.
//  When rsp stalls with both stages full, req.ready drops in the same cycle;
//  with stage 1 empty, one more instruction is taken first.

module mips_execute_memory_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	mips_em_req_if.sink                         req,
	mips_em_rsp_if.source                       rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mips_em_pkg::PADDR_W-1:0]     paddr,
	input  logic [mips_em_pkg::WORD_W-1:0]      pwdata,
	output logic [mips_em_pkg::WORD_W-1:0]      prdata,
	output logic                                pready
);

	localparam int ROW_W = mips_em_pkg::ROW_W;
	localparam int LANES = mips_em_pkg::LANES;

	// Configuration and architectural state
	logic [31:0] start_pc_q;
	logic [31:0] pc_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;

	// Memory clearing pass
	logic             clearing_q;
	logic [ROW_W-1:0] clr_idx_q;

	// Pipeline control
	logic accept;
	logic adv_s2;
	logic valid_s1;
	logic valid_s2;

	// Execute-stage signals
	mips_em_pkg::op_t op;
	logic [31:0] imm_sext;
	logic [31:0] uimm;
	logic [4:0]  sh;
	logic [31:0] pc4;
	logic [31:0] target;
	logic [31:0] ea;
	logic [31:0] res;
	logic [31:0] npc;
	logic [31:0] addr;
	logic        is_store;
	logic [2:0]  nbytes;
	logic [31:0] st_word;
	logic        mul_en;
	logic [32:0] mul_a;
	logic [32:0] mul_b;
	logic [63:0] product;

	// Byte lanes
	logic [ROW_W-1:0] lane_addr  [LANES];
	logic             lane_we    [LANES];
	logic [7:0]       lane_wdata [LANES];
	logic [7:0]       lane_rdata [LANES];

	// Stage 1 (memory read returned)
	mips_em_pkg::op_t op_s1;
	logic [1:0]  off_s1;
	logic [31:0] res_s1;
	logic [31:0] addr_s1;
	logic [31:0] npc_s1;
	logic [7:0]  ld_byte [LANES];
	logic [31:0] final_s1;

	// Stage 2 (output register)
	logic [31:0] result_s2;
	logic [31:0] data_address_s2;
	logic [31:0] next_pc_s2;

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mips_em_pkg::REG_START_PC) ? start_pc_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == mips_em_pkg::REG_START_PC) begin
			start_pc_q <= pwdata;
		end
	end

	// Handshake
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign req.ready = !clearing_q && (!valid_s1 || adv_s2);
	assign accept    = req.valid && req.ready;

	// Decode immediates and addresses
	always_comb begin
		op       = mips_em_pkg::op_t'(req.mode);
		imm_sext = {{16{req.imm_field[15]}}, req.imm_field[15:0]};
		uimm     = {16'b0, req.imm_field[15:0]};
		sh       = req.imm_field[4:0];
		pc4      = pc_q + 32'd4;
		target   = pc4 + {imm_sext[29:0], 2'b00};
		ea       = req.rs_value + imm_sext;
	end

	// Execute: ALU result, address, next PC and store shaping
	always_comb begin
		res      = '0;
		addr     = '0;
		npc      = pc4;
		is_store = 1'b0;
		nbytes   = 3'd4;
		st_word  = req.rt_value;
		mul_en   = 1'b0;
		unique case (op) inside
			mips_em_pkg::OP_ADD, mips_em_pkg::OP_ADDU:
				res = req.rs_value + req.rt_value;
			mips_em_pkg::OP_SUB:  res = req.rs_value - req.rt_value;
			mips_em_pkg::OP_AND:  res = req.rs_value & req.rt_value;
			mips_em_pkg::OP_OR:   res = req.rs_value | req.rt_value;
			mips_em_pkg::OP_XOR:  res = req.rs_value ^ req.rt_value;
			mips_em_pkg::OP_NOR:  res = ~(req.rs_value | req.rt_value);
			mips_em_pkg::OP_NAND: res = ~(req.rs_value & req.rt_value);
			mips_em_pkg::OP_SLT:
				res = {31'b0, $signed(req.rs_value) < $signed(req.rt_value)};
			mips_em_pkg::OP_SLL:  res = req.rt_value << sh;
			mips_em_pkg::OP_SRL:  res = req.rt_value >> sh;
			mips_em_pkg::OP_SRA:  res = 32'($signed(req.rt_value) >>> sh);
			mips_em_pkg::OP_JR:   npc = req.rs_value;
			mips_em_pkg::OP_MULT, mips_em_pkg::OP_MULTU:
				mul_en = 1'b1;
			mips_em_pkg::OP_MFHI: res = hi_q;
			mips_em_pkg::OP_MFLO: res = lo_q;
			mips_em_pkg::OP_ADDI, mips_em_pkg::OP_ADDIU:
				res = req.rs_value + imm_sext;
			mips_em_pkg::OP_LW, mips_em_pkg::OP_LH, mips_em_pkg::OP_LHU,
			mips_em_pkg::OP_LB, mips_em_pkg::OP_LBU:
				addr = ea;
			mips_em_pkg::OP_SW: begin
				addr     = ea;
				res      = req.rt_value;
				is_store = 1'b1;
			end
			mips_em_pkg::OP_SH: begin
				addr     = ea;
				res      = req.rt_value & mips_em_pkg::HALF_MASK;
				is_store = 1'b1;
				nbytes   = 3'd2;
				st_word  = {req.rt_value[15:0], 16'b0};
			end
			mips_em_pkg::OP_SB: begin
				addr     = ea;
				res      = req.rt_value & mips_em_pkg::BYTE_MASK;
				is_store = 1'b1;
				nbytes   = 3'd1;
				st_word  = {req.rt_value[7:0], 24'b0};
			end
			mips_em_pkg::OP_LUI:  res = {uimm[15:0], 16'b0};
			mips_em_pkg::OP_ANDI: res = req.rs_value & uimm;
			mips_em_pkg::OP_ORI:  res = req.rs_value | uimm;
			mips_em_pkg::OP_NORI: res = ~(req.rs_value | uimm);
			mips_em_pkg::OP_SLTI:
				res = {31'b0, $signed(req.rs_value) < $signed(imm_sext)};
			mips_em_pkg::OP_BEQ:
				if (req.rs_value == req.rt_value) npc = target;
			mips_em_pkg::OP_BNE:
				if (req.rs_value != req.rt_value) npc = target;
			mips_em_pkg::OP_BGTZ:
				if (req.rs_value != '0 && !req.rs_value[31]) npc = target;
			mips_em_pkg::OP_J:
				npc = (pc4 & mips_em_pkg::TOP_NIBBLE_MASK) | {4'b0, req.imm_field, 2'b00};
			mips_em_pkg::OP_JAL: begin
				npc = (pc4 & mips_em_pkg::TOP_NIBBLE_MASK) | {4'b0, req.imm_field, 2'b00};
				res = pc4;
			end
			default: ;
		endcase
	end

	// Multiply operands: sign-extend for mult, zero-extend for multu
	assign mul_a   = {(op == mips_em_pkg::OP_MULT) & req.rs_value[31], req.rs_value};
	assign mul_b   = {(op == mips_em_pkg::OP_MULT) & req.rt_value[31], req.rt_value};
	assign product = 64'($signed(mul_a) * $signed(mul_b));

	// Advance PC at each transfer and HI/LO on each multiply (PC and start_pc reset to zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
		end else if (accept) begin
			pc_q <= npc;
			if (mul_en) begin
				hi_q <= product[63:32];
				lo_q <= product[31:0];
			end
		end
	end

	// Clear the data memory one row at a time after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == ROW_W'(mips_em_pkg::ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Steer each byte lane: row wraps to the next one below the start offset
	always_comb begin
		logic [1:0] k;
		for (int l = 0; l < LANES; l++) begin
			k = 2'(l) - ea[1:0];
			if (clearing_q) begin
				lane_addr[l]  = clr_idx_q;
				lane_we[l]    = 1'b1;
				lane_wdata[l] = '0;
			end else begin
				lane_addr[l]  = ea[ROW_W+1:2] + ROW_W'(2'(l) < ea[1:0]);
				lane_we[l]    = accept && is_store && ({1'b0, k} < nbytes);
				lane_wdata[l] = st_word[{2'd3 - k, 3'b000} +: 8];
			end
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		mips_em_ram #(
			.WIDTH (8),
			.DEPTH (mips_em_pkg::ROWS)
		) u_ram (
			.clk   (clk),
			.we    (lane_we[g]),
			.re    (accept),
			.addr  (lane_addr[g]),
			.wdata (lane_wdata[g]),
			.rdata (lane_rdata[g])
		);
	end

	// Stage 1 registers: hold while the output register is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op;
			off_s1  <= ea[1:0];
			res_s1  <= res;
			addr_s1 <= addr;
			npc_s1  <= npc;
		end
	end

	// Assemble big-endian load data from the lanes
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			ld_byte[k] = lane_rdata[2'(off_s1 + 2'(k))];
		end
		case (op_s1)
			mips_em_pkg::OP_LW:
				final_s1 = {ld_byte[0], ld_byte[1], ld_byte[2], ld_byte[3]};
			mips_em_pkg::OP_LH:
				final_s1 = {{16{ld_byte[0][7]}}, ld_byte[0], ld_byte[1]};
			mips_em_pkg::OP_LHU:
				final_s1 = {16'b0, ld_byte[0], ld_byte[1]};
			mips_em_pkg::OP_LB:
				final_s1 = {{24{ld_byte[0][7]}}, ld_byte[0]};
			mips_em_pkg::OP_LBU:
				final_s1 = {24'b0, ld_byte[0]};
			default:
				final_s1 = res_s1;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2       <= final_s1;
			data_address_s2 <= addr_s1;
			next_pc_s2      <= npc_s1;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.result       = result_s2;
	assign rsp.data_address = data_address_s2;
	assign rsp.next_pc      = next_pc_s2;

endmodule

FILE: rtl/mips_em_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Width and depth are parameters; no package dependencies.
`timescale 1ns / 1ps

module mips_em_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, register read data on read enable (holds otherwise)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
